// File: rtl/dchs_pkg.sv
// Shared constants, types and derived widths of the dual-channel history smoother.
package dchs_pkg;

    // Number of past values averaged per channel (2 to 256).
    localparam int HISTORY_DEPTH = 50;

    localparam int SAMPLE_W = 12;
    localparam int POS_W    = $clog2(HISTORY_DEPTH);
    localparam int RING_W   = 2 * SAMPLE_W;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE    = 12'd4095;
    localparam logic [SAMPLE_W-1:0] DEFAULT_LEVEL = 12'd2000;

    // Running sums of one ring.
    localparam int SUM_MAX = 4095 * HISTORY_DEPTH;
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(2000 * HISTORY_DEPTH);

    // Mean by reciprocal multiplication, exact for every sum below 2**SUM_W.
    localparam int     MEAN_SHIFT   = SUM_W + $clog2(HISTORY_DEPTH);
    localparam longint MEAN_RECIP   = (64'd1 << MEAN_SHIFT) / HISTORY_DEPTH + 1;
    localparam int     MEAN_RECIP_W = SUM_W + 2;
    localparam int     MEAN_PROD_W  = SUM_W + MEAN_RECIP_W;

    // Blend (CURRENT_WEIGHT * held + MEAN_WEIGHT * mean) / BLEND_DIVISOR.
    localparam int     CURRENT_WEIGHT = 2;
    localparam int     MEAN_WEIGHT    = 8;
    localparam int     BLEND_DIVISOR  = 10;
    localparam int     BLEND_W        = 16;
    localparam int     BLEND_SHIFT    = BLEND_W + $clog2(BLEND_DIVISOR);
    localparam longint BLEND_RECIP    = (64'd1 << BLEND_SHIFT) / BLEND_DIVISOR + 1;
    localparam int     BLEND_RECIP_W  = BLEND_W + 2;
    localparam int     BLEND_PROD_W   = BLEND_W + BLEND_RECIP_W;

    // Output buffer; its depth also bounds the beats in flight.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_REFILL = 1'b1
    } func_t;

    // A finished history update: held values and the sums that include them.
    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] held_ns;
        logic [SAMPLE_W-1:0] held_ew;
        logic [SUM_W-1:0]    sum_ns;
        logic [SUM_W-1:0]    sum_ew;
    } hist_out_t;

    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] ns;
        logic [SAMPLE_W-1:0] ew;
    } result_t;

endpackage

// File: rtl/dual_channel_history_smoother_core.sv
// Top level of the dual-channel history smoother.
//
// The block takes one beat per clock cycle at full rate while s_tready is high. Each
// sample beat inverts its reading into the held value of one channel, then pushes both
// held values into a shared history RAM at one write position through a
// read-modify-write, keeps a running sum per channel and returns one result beat (mean
// by reciprocal multiplication, then the 2:8 blend, then the output buffer). A refill beat
// returns both histories to the default level of 2000 and yields no result; per-entry valid
// bits make this immediate, with no clearing pass after reset or refill. The history update
// sets the rate; an eight-beat output buffer absorbs back-pressure, and s_tready falls only
// once eight results are outstanding. smart_mode selects the smoothed values (1) or the held
// values (0); the user must write it via the cfg channel only while idle (not enforced).
module dual_channel_history_smoother_core
    import dchs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] adc_sample, [15:12] zero
    input  logic [1:0]  s_tuser,   // [0] func, [1] edit_east_west

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [11:0] north_south_value, [23:12] east_west_value

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // smart_mode
);

    logic                smart_mode_reg;
    logic [CREDIT_W-1:0] credit_reg, credit_next;
    logic                in_accept;
    logic                out_accept;
    logic                result_taken;
    func_t               in_func;
    hist_out_t           hist;
    result_t             result;

    assign in_func    = func_t'(s_tuser[0]);
    assign s_tready   = (credit_reg < CREDIT_W'(FIFO_DEPTH));
    assign in_accept  = s_tvalid && s_tready;
    assign out_accept = m_tvalid && m_tready;
    assign cfg_ready  = 1'b1;

    // Every sample beat reserves a place in the output buffer until its result leaves.
    assign result_taken = in_accept && (in_func == FUNC_SAMPLE);

    always_comb begin
        case ({result_taken, out_accept})
            2'b10:   credit_next = credit_reg + 1'b1;
            2'b01:   credit_next = credit_reg - 1'b1;
            default: credit_next = credit_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smart_mode_reg <= 1'b0;
            credit_reg     <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                smart_mode_reg <= cfg_data;
            end
            credit_reg <= credit_next;
        end
    end

    dchs_history u_history (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (in_accept),
        .in_func      (in_func),
        .in_sample    (s_tdata[SAMPLE_W-1:0]),
        .in_east_west (s_tuser[1]),
        .hist_out     (hist)
    );

    dchs_smooth u_smooth (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .smart_mode (smart_mode_reg),
        .hist_in    (hist),
        .result     (result)
    );

    dchs_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_in   (result),
        .pop       (out_accept),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

    a_credit_covers_output: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> credit_reg != '0)
        else $error("result beat offered without an outstanding sample");

    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_reg <= CREDIT_W'(FIFO_DEPTH))
        else $error("more results outstanding than the output buffer holds");

endmodule

// File: rtl/dchs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module dchs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/dchs_history.sv
// Held values, history RAM read-modify-write and running sums of both channels.
module dchs_history
    import dchs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  func_t               in_func,
    input  logic [SAMPLE_W-1:0] in_sample,
    input  logic                in_east_west,
    output hist_out_t           hist_out
);

    logic [SAMPLE_W-1:0]      held_ns_reg, held_ns_next;
    logic [SAMPLE_W-1:0]      held_ew_reg, held_ew_next;
    logic [POS_W-1:0]         pos_reg, pos_next;

    logic                     s1_valid_reg;
    logic                     s1_refill_reg;
    logic [POS_W-1:0]         s1_pos_reg;
    logic [SAMPLE_W-1:0]      s1_ns_reg;
    logic [SAMPLE_W-1:0]      s1_ew_reg;

    logic [HISTORY_DEPTH-1:0] valid_bits_reg, valid_bits_next;
    logic [SUM_W-1:0]         sum_ns_reg, sum_ns_next;
    logic [SUM_W-1:0]         sum_ew_reg, sum_ew_next;

    logic                     done_valid_reg;
    logic [SAMPLE_W-1:0]      done_ns_reg;
    logic [SAMPLE_W-1:0]      done_ew_reg;

    logic                     is_sample;
    logic [RING_W-1:0]        ring_rdata;
    logic                     entry_valid;
    logic [SAMPLE_W-1:0]      old_ns;
    logic [SAMPLE_W-1:0]      old_ew;

    assign is_sample = in_accept && (in_func == FUNC_SAMPLE);

    always_comb begin
        held_ns_next = held_ns_reg;
        held_ew_next = held_ew_reg;
        pos_next     = pos_reg;
        if (is_sample) begin
            if (in_east_west) begin
                held_ew_next = FULL_SCALE - in_sample;
            end else begin
                held_ns_next = FULL_SCALE - in_sample;
            end
            pos_next = (pos_reg == POS_W'(HISTORY_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
        end
    end

    // Both channels share one write position, so one RAM word holds the pair.
    // Consecutive samples never hit the same entry, so no forwarding is needed.
    dchs_ram #(
        .WIDTH (RING_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .clk   (aclk),
        .we    (s1_valid_reg),
        .waddr (s1_pos_reg),
        .wdata ({s1_ew_reg, s1_ns_reg}),
        .re    (is_sample),
        .raddr (pos_reg),
        .rdata (ring_rdata)
    );

    // An entry not written since the last refill reads as the default level.
    assign entry_valid = valid_bits_reg[s1_pos_reg];
    assign old_ns      = entry_valid ? ring_rdata[SAMPLE_W-1:0] : DEFAULT_LEVEL;
    assign old_ew      = entry_valid ? ring_rdata[RING_W-1:SAMPLE_W] : DEFAULT_LEVEL;

    always_comb begin
        valid_bits_next = valid_bits_reg;
        sum_ns_next     = sum_ns_reg;
        sum_ew_next     = sum_ew_reg;
        if (s1_refill_reg) begin
            valid_bits_next = '0;
            sum_ns_next     = SUM_RESET;
            sum_ew_next     = SUM_RESET;
        end else if (s1_valid_reg) begin
            valid_bits_next[s1_pos_reg] = 1'b1;
            sum_ns_next = sum_ns_reg - SUM_W'(old_ns) + SUM_W'(s1_ns_reg);
            sum_ew_next = sum_ew_reg - SUM_W'(old_ew) + SUM_W'(s1_ew_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_ns_reg    <= '0;
            held_ew_reg    <= '0;
            pos_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s1_refill_reg  <= 1'b0;
            valid_bits_reg <= '0;
            sum_ns_reg     <= SUM_RESET;
            sum_ew_reg     <= SUM_RESET;
            done_valid_reg <= 1'b0;
        end else begin
            held_ns_reg    <= held_ns_next;
            held_ew_reg    <= held_ew_next;
            pos_reg        <= pos_next;
            s1_valid_reg   <= is_sample;
            s1_refill_reg  <= in_accept && (in_func == FUNC_REFILL);
            valid_bits_reg <= valid_bits_next;
            sum_ns_reg     <= sum_ns_next;
            sum_ew_reg     <= sum_ew_next;
            done_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_pos_reg  <= pos_reg;
        s1_ns_reg   <= held_ns_next;
        s1_ew_reg   <= held_ew_next;
        done_ns_reg <= s1_ns_reg;
        done_ew_reg <= s1_ew_reg;
    end

    assign hist_out = '{
        valid:   done_valid_reg,
        held_ns: done_ns_reg,
        held_ew: done_ew_reg,
        sum_ns:  sum_ns_reg,
        sum_ew:  sum_ew_reg
    };

    a_refill_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_refill_reg |=> (valid_bits_reg == '0) && (sum_ns_reg == SUM_RESET))
        else $error("refill did not restore the history");

    a_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (sum_ns_reg <= SUM_W'(SUM_MAX)) && (sum_ew_reg <= SUM_W'(SUM_MAX)))
        else $error("running sum left the range of a full ring");

endmodule

// File: rtl/dchs_smooth.sv
// Mean and blend pipeline, with the choice between smoothed and held values.
module dchs_smooth
    import dchs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      smart_mode,
    input  hist_out_t hist_in,
    output result_t   result
);

    logic [MEAN_PROD_W-1:0]  mean_prod_ns;
    logic [MEAN_PROD_W-1:0]  mean_prod_ew;

    logic                    s2_valid_reg;
    logic [SAMPLE_W-1:0]     s2_mean_ns_reg;
    logic [SAMPLE_W-1:0]     s2_mean_ew_reg;
    logic [SAMPLE_W-1:0]     s2_held_ns_reg;
    logic [SAMPLE_W-1:0]     s2_held_ew_reg;

    logic [BLEND_W-1:0]      blend_ns;
    logic [BLEND_W-1:0]      blend_ew;
    logic [BLEND_PROD_W-1:0] blend_prod_ns;
    logic [BLEND_PROD_W-1:0] blend_prod_ew;
    logic [SAMPLE_W-1:0]     smooth_ns;
    logic [SAMPLE_W-1:0]     smooth_ew;

    assign mean_prod_ns = MEAN_PROD_W'(hist_in.sum_ns) * MEAN_PROD_W'(MEAN_RECIP);
    assign mean_prod_ew = MEAN_PROD_W'(hist_in.sum_ew) * MEAN_PROD_W'(MEAN_RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= hist_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        s2_mean_ns_reg <= mean_prod_ns[MEAN_SHIFT +: SAMPLE_W];
        s2_mean_ew_reg <= mean_prod_ew[MEAN_SHIFT +: SAMPLE_W];
        s2_held_ns_reg <= hist_in.held_ns;
        s2_held_ew_reg <= hist_in.held_ew;
    end

    assign blend_ns = BLEND_W'(s2_held_ns_reg) * BLEND_W'(CURRENT_WEIGHT)
                    + BLEND_W'(s2_mean_ns_reg) * BLEND_W'(MEAN_WEIGHT);
    assign blend_ew = BLEND_W'(s2_held_ew_reg) * BLEND_W'(CURRENT_WEIGHT)
                    + BLEND_W'(s2_mean_ew_reg) * BLEND_W'(MEAN_WEIGHT);

    assign blend_prod_ns = BLEND_PROD_W'(blend_ns) * BLEND_PROD_W'(BLEND_RECIP);
    assign blend_prod_ew = BLEND_PROD_W'(blend_ew) * BLEND_PROD_W'(BLEND_RECIP);

    assign smooth_ns = blend_prod_ns[BLEND_SHIFT +: SAMPLE_W];
    assign smooth_ew = blend_prod_ew[BLEND_SHIFT +: SAMPLE_W];

    assign result = '{
        valid: s2_valid_reg,
        ns:    smart_mode ? smooth_ns : s2_held_ns_reg,
        ew:    smart_mode ? smooth_ew : s2_held_ew_reg
    };

endmodule

// File: rtl/dchs_out_fifo.sv
// Output buffer that holds finished result beats until the sink takes them.
module dchs_out_fifo
    import dchs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  result_t           push_in,
    input  logic              pop,
    output logic              out_valid,
    output logic [RING_W-1:0] out_data
);

    logic [RING_W-1:0]   mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CREDIT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_in.valid) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push_in.valid, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_in.valid) begin
            mem_reg[wr_ptr_reg] <= {push_in.ew, push_in.ns};
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_in.valid && !pop |-> count_reg < CREDIT_W'(FIFO_DEPTH))
        else $error("result written into a full output buffer");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the dual-channel history smoother core.
`timescale 1ns / 100ps

module testbench
    import dchs_pkg::*;
();

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int TAIL_CYCLES     = 16;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASE_ITEMS     = 276;
    localparam int NUM_PHASES      = 5;
    localparam int WATCHDOG_CYCLES = 600_000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] ew;
        logic [SAMPLE_W-1:0] ns;
    } channel_pair_t;

    // Keeps its own copy of both histories and predicts each result beat.
    class smoother_scoreboard;
        logic [SAMPLE_W-1:0] ring_copy_ns [HISTORY_DEPTH];
        logic [SAMPLE_W-1:0] ring_copy_ew [HISTORY_DEPTH];
        int unsigned         total_ns;
        int unsigned         total_ew;
        int unsigned         slot;
        logic [SAMPLE_W-1:0] held_ns;
        logic [SAMPLE_W-1:0] held_ew;
        bit                  smart_mode;
        channel_pair_t       awaited_pairs[$];
        int unsigned         mismatches;
        int unsigned         beats_checked;

        function new();
            restore_histories();
            slot       = 0;
            held_ns    = '0;
            held_ew    = '0;
            smart_mode = 1'b0;
        endfunction

        function void restore_histories();
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                ring_copy_ns[i] = DEFAULT_LEVEL;
                ring_copy_ew[i] = DEFAULT_LEVEL;
            end
            total_ns = 2000 * HISTORY_DEPTH;
            total_ew = 2000 * HISTORY_DEPTH;
        endfunction

        function logic [SAMPLE_W-1:0] blend(int unsigned held, int unsigned total);
            return SAMPLE_W'((2 * held + 8 * (total / HISTORY_DEPTH)) / 10);
        endfunction

        function int unsigned pending();
            return awaited_pairs.size();
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        function void note_input(func_t func, logic [SAMPLE_W-1:0] sample, bit east_west);
            channel_pair_t pair;
            if (func == FUNC_REFILL) begin
                restore_histories();
                return;
            end
            if (east_west)
                held_ew = FULL_SCALE - sample;
            else
                held_ns = FULL_SCALE - sample;
            total_ns = total_ns - ring_copy_ns[slot] + held_ns;
            total_ew = total_ew - ring_copy_ew[slot] + held_ew;
            ring_copy_ns[slot] = held_ns;
            ring_copy_ew[slot] = held_ew;
            slot = (slot + 1 >= HISTORY_DEPTH) ? 0 : slot + 1;
            if (smart_mode) begin
                pair.ns = blend(held_ns, total_ns);
                pair.ew = blend(held_ew, total_ew);
            end else begin
                pair.ns = held_ns;
                pair.ew = held_ew;
            end
            awaited_pairs.push_back(pair);
        endfunction

        task check_result(logic [23:0] beat);
            channel_pair_t want;
            beats_checked++;
            if (awaited_pairs.size() == 0) begin
                report($sformatf("result beat %0d (0x%06h) arrived with none expected",
                                 beats_checked, beat));
                return;
            end
            want = awaited_pairs.pop_front();
            if (beat[11:0] !== want.ns)
                report($sformatf("beat %0d north_south_value got %0d expected %0d",
                                 beats_checked, beat[11:0], want.ns));
            if (beat[23:12] !== want.ew)
                report($sformatf("beat %0d east_west_value got %0d expected %0d",
                                 beats_checked, beat[23:12], want.ew));
        endtask
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // [11:0] adc_sample, [15:12] zero
    logic [1:0]  s_tuser   = '0;   // [0] func, [1] edit_east_west
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // [11:0] north_south_value, [23:12] east_west_value
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;

    smoother_scoreboard sb = new();

    bit          hold_off_request = 1'b0;
    int unsigned hold_offs_done;
    int unsigned samples_sent;
    int unsigned refills_sent;
    int unsigned mode_writes;

    dual_channel_history_smoother_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Offers one beat and returns at the edge that accepts it; valid stays high.
    task automatic send_item(input func_t func, input logic [SAMPLE_W-1:0] sample,
                             input bit east_west);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, sample};
        s_tuser  <= {east_west, func};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(func, sample, east_west);
        if (func == FUNC_REFILL)
            refills_sent++;
        else
            samples_sent++;
    endtask

    // Stops offering and waits until every predicted result has been seen.
    task automatic drain();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // A refill beat yields nothing, so allow for one still in the pipeline.
    task automatic write_mode(input bit mode);
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.smart_mode = mode;
        mode_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic directed_pass();
        send_item(FUNC_SAMPLE, 12'd0,    1'b0);
        send_item(FUNC_SAMPLE, 12'd4095, 1'b1);
        send_item(FUNC_SAMPLE, 12'd4095, 1'b0);
        send_item(FUNC_SAMPLE, 12'd0,    1'b1);
        send_item(FUNC_SAMPLE, 12'hAAA,  1'b0);
        send_item(FUNC_SAMPLE, 12'h555,  1'b1);
        // Two refills back to back; the sample field must be ignored.
        send_item(FUNC_REFILL, 12'hFFF,  1'b1);
        send_item(FUNC_REFILL, 12'h000,  1'b0);
        send_item(FUNC_SAMPLE, 12'd0,    1'b1);
        send_item(FUNC_SAMPLE, 12'd2095, 1'b0);
        send_item(FUNC_SAMPLE, 12'hFFF,  1'b1);
        send_item(FUNC_SAMPLE, 12'd1,    1'b0);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 12'd0;
            1:       return 12'd4095;
            default: return SAMPLE_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // Random bursts; refill_odds of zero gives long runs that wrap the histories.
    task automatic random_phase(input int unsigned count, input int unsigned refill_odds,
                                input bit with_hold, input bit with_pause);
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        func_t       func;
        sent = 0;
        while (sent < count) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 20);
            for (int i = 0; i < burst && sent < count; i++) begin
                func = (refill_odds != 0 && $urandom_range(1, refill_odds) == 1)
                       ? FUNC_REFILL : FUNC_SAMPLE;
                send_item(func, pick_sample(), 1'($urandom_range(0, 1)));
                sent++;
                if (with_hold && sent == count / 3)
                    hold_off_request = 1'b1;
                if (with_pause && sent == count / 2)
                    drain();
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Result side: checks every accepted beat and stalls on its own pattern.
    initial begin : result_sink
        int unsigned hold_left;
        int unsigned pattern;
        int unsigned pattern_left;
        hold_left    = 0;
        pattern      = 0;
        pattern_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left = HOLD_CYCLES;
                hold_offs_done++;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern      = $urandom_range(0, 3);
                    pattern_left = $urandom_range(16, 120);
                end
                pattern_left--;
                case (pattern)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 4) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_mode(1'b0);
        directed_pass();
        write_mode(1'b1);
        directed_pass();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_mode(p[0] == 1'b0);
            case (p)
                0:       random_phase(PHASE_ITEMS, 40, 1'b0, 1'b0);
                1:       random_phase(PHASE_ITEMS, 0,  1'b1, 1'b0);
                2:       random_phase(PHASE_ITEMS, 40, 1'b0, 1'b1);
                3:       random_phase(PHASE_ITEMS, 8,  1'b1, 1'b0);
                default: random_phase(PHASE_ITEMS, 25, 1'b0, 1'b0);
            endcase
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));

        $display("Covered %0d sample beats and %0d refills, %0d results checked.",
                 samples_sent, refills_sent, sb.beats_checked);
        $display("Mode register written %0d times, %0d long receiver hold-offs.",
                 mode_writes, hold_offs_done);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_CYCLES * 2 * HALF_PERIOD);
        $display("Timed out with %0d results outstanding.", sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
